// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_RST(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== rtl/core/ilp_pkg.sv =====
package ilp_pkg;

	typedef enum logic [1:0] {
		KIND_DEC = 2'd0,
		KIND_HEX = 2'd1,
		KIND_OCT = 2'd2,
		KIND_BIN = 2'd3
	} kind_t;

	localparam logic [7:0] CHAR_SEP  = 8'h27;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;
	localparam logic [1:0] POS_SAT   = 2'd2;

	typedef struct packed {
		logic [63:0] acc;
		kind_t       kind;
		logic [1:0]  pos;
		logic        digit_seen;
		logic        bad_digit;
		logic        ovf;
		logic        bad_start;
		logic        first_zero;
	} state_t;

	typedef struct packed {
		logic [63:0] value;
		kind_t       base_kind;
		logic        bad_digit;
		logic        overflowed;
		logic        no_digits;
		logic        bad_start;
	} result_t;

	localparam state_t STATE_RST = '{
		acc:        64'd0,
		kind:       KIND_DEC,
		pos:        2'd0,
		digit_seen: 1'b0,
		bad_digit:  1'b0,
		ovf:        1'b0,
		bad_start:  1'b0,
		first_zero: 1'b0
	};

endpackage

// ===== rtl/core/ilp_step.sv =====
module ilp_step (
	input  ilp_pkg::state_t  st,
	input  logic [7:0]       char_code,
	output ilp_pkg::state_t  nxt,
	output ilp_pkg::result_t res
);

	ilp_pkg::kind_t pfx;
	logic           is_dec;
	logic           consumed;
	logic           dig_ok;
	logic [3:0]     dig;
	logic [67:0]    dec_wide;
	logic [63:0]    acc_new;
	logic           ovf_now;

	assign is_dec = char_code inside {["0":"9"]};

	always_comb begin
		case (char_code)
			"x", "X": pfx = ilp_pkg::KIND_HEX;
			"o", "O": pfx = ilp_pkg::KIND_OCT;
			"b", "B": pfx = ilp_pkg::KIND_BIN;
			default:  pfx = ilp_pkg::KIND_DEC;
		endcase
	end

	always_comb begin
		dig_ok = 1'b0;
		dig    = 4'd0;
		case (st.kind)
			ilp_pkg::KIND_HEX: begin
				if (is_dec) begin
					dig_ok = 1'b1;
					dig    = 4'(char_code - ilp_pkg::CHAR_ZERO);
				end else if (char_code inside {["a":"f"]}) begin
					dig_ok = 1'b1;
					dig    = 4'(char_code - "a" + 8'd10);
				end else if (char_code inside {["A":"F"]}) begin
					dig_ok = 1'b1;
					dig    = 4'(char_code - "A" + 8'd10);
				end
			end
			ilp_pkg::KIND_OCT: begin
				dig_ok = char_code inside {["0":"7"]};
				dig    = 4'(char_code - ilp_pkg::CHAR_ZERO);
			end
			ilp_pkg::KIND_BIN: begin
				dig_ok = char_code inside {["0":"1"]};
				dig    = 4'(char_code - ilp_pkg::CHAR_ZERO);
			end
			default: begin
				dig_ok = is_dec;
				dig    = 4'(char_code - ilp_pkg::CHAR_ZERO);
			end
		endcase
	end

	// acc*10 + d; any bit above 63 means the 64-bit value wrapped
	assign dec_wide = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {64'd0, dig};

	always_comb begin
		case (st.kind)
			ilp_pkg::KIND_HEX: begin
				acc_new = {st.acc[59:0], dig};
				ovf_now = |st.acc[63:60];
			end
			ilp_pkg::KIND_OCT: begin
				acc_new = {st.acc[60:0], dig[2:0]};
				ovf_now = |st.acc[63:61];
			end
			ilp_pkg::KIND_BIN: begin
				acc_new = {st.acc[62:0], dig[0]};
				ovf_now = st.acc[63];
			end
			default: begin
				acc_new = dec_wide[63:0];
				ovf_now = |dec_wide[67:64];
			end
		endcase
	end

	always_comb begin
		nxt      = st;
		consumed = 1'b0;
		if (st.pos == 2'd0) begin
			if (char_code == ilp_pkg::CHAR_ZERO) nxt.first_zero = 1'b1;
			if (!is_dec && char_code != ilp_pkg::CHAR_DOT) nxt.bad_start = 1'b1;
		end else if (st.pos == 2'd1 && st.first_zero && pfx != ilp_pkg::KIND_DEC) begin
			// prefix letter after a leading zero: restart in the new base
			nxt.kind       = pfx;
			nxt.acc        = 64'd0;
			nxt.digit_seen = 1'b0;
			consumed       = 1'b1;
		end

		if (!consumed && char_code != ilp_pkg::CHAR_SEP) begin
			nxt.digit_seen = 1'b1;
			if (!dig_ok) begin
				nxt.bad_digit = 1'b1;
			end else begin
				if (ovf_now) nxt.ovf = 1'b1;
				nxt.acc = acc_new;
			end
		end

		if (st.pos != ilp_pkg::POS_SAT) nxt.pos = st.pos + 2'd1;
	end

	always_comb begin
		res.value      = nxt.acc;
		res.base_kind  = nxt.kind;
		res.bad_digit  = nxt.bad_digit;
		res.overflowed = nxt.ovf;
		res.no_digits  = !nxt.digit_seen;
		res.bad_start  = nxt.bad_start && (nxt.kind == ilp_pkg::KIND_DEC);
	end

endmodule

// ===== rtl/core/integer_literal_parser_top.sv =====
// Integer literal parser.
// Input stream: one character per beat on s_tdata, s_tlast on the final
// character of a literal. A leading 0x/0o/0b (either case) selects the base,
// apostrophes are skipped, digits are accumulated modulo 2^64.
// Output stream: one beat per literal, sent for the beat that carried
// s_tlast. m_tdata holds the value, m_tuser the base and status flags.
// Path: a character enters the input register; a final one then loads the
// result register. Throughput is one character per cycle unless a final
// character waits (see Stall); the per-character update is a single
// shift-and-add from the input register into the parser state.
// Stall: while a result waits on m_tready, non-final characters still flow
// in; a final character waits in the input register until the result
// register frees, and s_tready is held low for as long as it waits.
// Reset: arst_n clears both valid flags and the parser state, so the next
// accepted character starts a new literal in decimal.
`include "assert_macros.svh"

module integer_literal_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value
	output logic [5:0]  m_tuser    // [1:0] base_kind, [2] bad_digit, [3] overflowed,
	                               // [4] no_digits, [5] bad_start
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             adv;
	logic             res_load;
	logic             kind_set;
	ilp_pkg::state_t  state_q;
	ilp_pkg::state_t  state_nxt;
	ilp_pkg::result_t res;

	// a final character needs the result register; others always move on
	assign adv      = valid_s1 && !(last_s1 && m_tvalid && !m_tready);
	assign s_tready = !valid_s1 || adv;

	assign res_load = adv && last_s1;
	assign kind_set = state_q.kind != ilp_pkg::KIND_DEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	ilp_step u_step (
		.st        (state_q),
		.char_code (char_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilp_pkg::STATE_RST;
		end else if (adv) begin
			state_q <= last_s1 ? ilp_pkg::STATE_RST : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			m_tdata <= res.value;
			m_tuser <= {res.bad_start, res.no_digits, res.overflowed, res.bad_digit,
				res.base_kind};
		end
	end

	`ASSERT_RST(a_res_src, clk, arst_n, $rose(m_tvalid) |-> $past(res_load), "stray result beat")
	`ASSERT_RST(a_clear, clk, arst_n, res_load |=> state_q == ilp_pkg::STATE_RST, "stale state")
	`ASSERT_ALWAYS(a_pos_sat, clk, !arst_n || state_q.pos != 2'd3, "position past saturation")
	`ASSERT_RST(a_prefix, clk, arst_n, kind_set |-> state_q.first_zero, "base without prefix")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASE_CHARS = 200;
	localparam int DIR_ROWS = 11;

	// idle percentages per phase: none, sender, receiver, both
	localparam int SEND_IDLE [4] = '{0, 66, 0, 21};
	localparam int RECV_STALL [4] = '{0, 0, 66, 21};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [63:0] value
	logic [5:0]  m_tuser;   // [1:0] base_kind, [2] bad_digit, [3] overflowed,
	                        // [4] no_digits, [5] bad_start

	integer_literal_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// literal being parsed, as the block should see it
	logic [63:0]     lit_acc;
	ilp_pkg::kind_t  lit_kind;
	logic [1:0]      lit_pos;
	bit              lit_seen;
	bit              lit_bad_digit;
	bit              lit_ovf;
	bit              lit_bad_start;
	bit              lit_lead_zero;

	ilp_pkg::result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int chars_sent = 0;
	int literals_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	// directed literals; rows with a typed result are checked against it
	string dir_text [DIR_ROWS] = '{
		"0x", "'", ".", "\377", "0", "0o7", "0B1'0", "0xaF", "09", "x1", "0b2"
	};
	bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0};
	ilp_pkg::result_t dir_want [DIR_ROWS] = '{
		'{64'd0,   ilp_pkg::KIND_HEX, 1'b0, 1'b0, 1'b1, 1'b0},
		'{64'd0,   ilp_pkg::KIND_DEC, 1'b0, 1'b0, 1'b1, 1'b1},
		'{64'd0,   ilp_pkg::KIND_DEC, 1'b1, 1'b0, 1'b0, 1'b0},
		'{64'd0,   ilp_pkg::KIND_DEC, 1'b1, 1'b0, 1'b0, 1'b1},
		'{64'd0,   ilp_pkg::KIND_DEC, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'd7,   ilp_pkg::KIND_OCT, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'd2,   ilp_pkg::KIND_BIN, 1'b0, 1'b0, 1'b0, 1'b0},
		'{64'd175, ilp_pkg::KIND_HEX, 1'b0, 1'b0, 1'b0, 1'b0},
		'0, '0, '0
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic clear_literal();
		lit_acc = '0;
		lit_kind = ilp_pkg::KIND_DEC;
		lit_pos = '0;
		lit_seen = 0;
		lit_bad_digit = 0;
		lit_ovf = 0;
		lit_bad_start = 0;
		lit_lead_zero = 0;
	endtask

	function automatic bit is_dec_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// value of c in base k, -1 when it is no digit of that base
	function automatic int digit_of(ilp_pkg::kind_t k, logic [7:0] c);
		case (k)
			ilp_pkg::KIND_HEX: begin
				if (is_dec_char(c)) return int'(c - ilp_pkg::CHAR_ZERO);
				if (c >= "a" && c <= "f") return int'(c - "a") + 10;
				if (c >= "A" && c <= "F") return int'(c - "A") + 10;
				return -1;
			end
			ilp_pkg::KIND_OCT:
				return (c >= "0" && c <= "7") ? int'(c - ilp_pkg::CHAR_ZERO) : -1;
			ilp_pkg::KIND_BIN:
				return (c == "0" || c == "1") ? int'(c - ilp_pkg::CHAR_ZERO) : -1;
			default: return is_dec_char(c) ? int'(c - ilp_pkg::CHAR_ZERO) : -1;
		endcase
	endfunction

	function automatic ilp_pkg::kind_t prefix_of(logic [7:0] c);
		if (c == "x" || c == "X") return ilp_pkg::KIND_HEX;
		if (c == "o" || c == "O") return ilp_pkg::KIND_OCT;
		if (c == "b" || c == "B") return ilp_pkg::KIND_BIN;
		return ilp_pkg::KIND_DEC;
	endfunction

	// overflow is tested before the shift-and-add; the value wraps anyway
	task automatic add_digit(input logic [63:0] d);
		case (lit_kind)
			ilp_pkg::KIND_HEX: begin
				if (lit_acc > (64'hFFFF_FFFF_FFFF_FFFF >> 4)) lit_ovf = 1;
				lit_acc = (lit_acc << 4) | d;
			end
			ilp_pkg::KIND_OCT: begin
				if (lit_acc > (64'hFFFF_FFFF_FFFF_FFFF >> 3)) lit_ovf = 1;
				lit_acc = (lit_acc << 3) | d;
			end
			ilp_pkg::KIND_BIN: begin
				if (lit_acc > (64'hFFFF_FFFF_FFFF_FFFF >> 1)) lit_ovf = 1;
				lit_acc = (lit_acc << 1) | d;
			end
			default: begin
				if (lit_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) lit_ovf = 1;
				lit_acc = lit_acc * 64'd10 + d;
			end
		endcase
	endtask

	task automatic parse_char(input logic [7:0] c, input bit last, output bit emits,
			output ilp_pkg::result_t res);
		int d;
		bit prefix_taken;
		prefix_taken = 0;
		if (lit_pos == 2'd0) begin
			if (c == ilp_pkg::CHAR_ZERO) lit_lead_zero = 1;
			if (!is_dec_char(c) && c != ilp_pkg::CHAR_DOT) lit_bad_start = 1;
		end else if (lit_pos == 2'd1 && lit_lead_zero
				&& prefix_of(c) != ilp_pkg::KIND_DEC) begin
			// prefix letter: drop the leading zero and switch base
			lit_kind = prefix_of(c);
			lit_acc = '0;
			lit_seen = 0;
			prefix_taken = 1;
		end
		if (!prefix_taken && c != ilp_pkg::CHAR_SEP) begin
			d = digit_of(lit_kind, c);
			lit_seen = 1;
			if (d < 0) lit_bad_digit = 1;
			else add_digit(64'(d));
		end
		if (lit_pos < ilp_pkg::POS_SAT) lit_pos = lit_pos + 2'd1;
		emits = last;
		res.value = lit_acc;
		res.base_kind = lit_kind;
		res.bad_digit = lit_bad_digit;
		res.overflowed = lit_ovf;
		res.no_digits = !lit_seen;
		res.bad_start = lit_bad_start && lit_kind == ilp_pkg::KIND_DEC;
		if (last) clear_literal();
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH %s", $time, what);
	endtask

	task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
			input ilp_pkg::result_t want);
		bit emits;
		ilp_pkg::result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		chars_sent++;
		parse_char(c, last, emits, res);
		if (emits) begin
			pending_results.push_back(typed ? want : res);
			literals_sent++;
		end
	endtask

	// mostly well-formed literals with random content, some noise
	task automatic send_random_literal();
		logic [7:0] text[$];
		ilp_pkg::kind_t base;
		int n_digits, max_digit, r, v;
		bit all_max;
		r = $urandom_range(99);
		if (r < 85) begin
			all_max = r < 6;
			base = all_max
				? ($urandom_range(1) ? ilp_pkg::KIND_HEX : ilp_pkg::KIND_BIN)
				: ilp_pkg::kind_t'($urandom_range(3));
			case (base)
				ilp_pkg::KIND_HEX: max_digit = 15;
				ilp_pkg::KIND_OCT: max_digit = 7;
				ilp_pkg::KIND_BIN: max_digit = 1;
				default: max_digit = 9;
			endcase
			if (base != ilp_pkg::KIND_DEC) begin
				text.push_back(ilp_pkg::CHAR_ZERO);
				case (base)
					ilp_pkg::KIND_HEX: text.push_back($urandom_range(1) ? "x" : "X");
					ilp_pkg::KIND_OCT: text.push_back($urandom_range(1) ? "o" : "O");
					default: text.push_back($urandom_range(1) ? "b" : "B");
				endcase
			end
			if (all_max) n_digits = (base == ilp_pkg::KIND_HEX) ? 16 : 64;
			else if ($urandom_range(9) == 0) begin
				// lengths around the 64-bit limit, some running past it
				case (base)
					ilp_pkg::KIND_HEX: n_digits = $urandom_range(14, 20);
					ilp_pkg::KIND_OCT: n_digits = $urandom_range(19, 25);
					ilp_pkg::KIND_BIN: n_digits = $urandom_range(60, 70);
					default: n_digits = $urandom_range(18, 24);
				endcase
			end else n_digits = $urandom_range(base == ilp_pkg::KIND_DEC ? 1 : 0, 8);
			for (int i = 0; i < n_digits; i++) begin
				r = all_max ? 99 : $urandom_range(99);
				if (r < 5) text.push_back(ilp_pkg::CHAR_SEP);
				else if (r < 9) text.push_back(8'($urandom_range(255)));
				else begin
					v = all_max ? max_digit : $urandom_range(max_digit);
					if (v < 10) text.push_back(ilp_pkg::CHAR_ZERO + 8'(v));
					else text.push_back(($urandom_range(1) ? "a" : "A") + 8'(v - 10));
				end
			end
		end else begin
			n_digits = $urandom_range(1, 6);
			for (int i = 0; i < n_digits; i++) begin
				if ($urandom_range(1)) text.push_back(8'($urandom_range(255)));
				else begin
					case ($urandom_range(7))
						0: text.push_back(ilp_pkg::CHAR_ZERO);
						1: text.push_back("x");
						2: text.push_back("B");
						3: text.push_back("o");
						4: text.push_back(ilp_pkg::CHAR_SEP);
						5: text.push_back(ilp_pkg::CHAR_DOT);
						6: text.push_back("9");
						default: text.push_back("f");
					endcase
				end
			end
		end
		foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, '0);
	endtask

	// receiver side
	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		ilp_pkg::result_t want;
		string bad;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%h user=%b",
					m_tdata, m_tuser));
			end else begin
				want = pending_results.pop_front();
				bad = "";
				if (m_tdata !== want.value) bad = {bad, " value"};
				if (m_tuser[1:0] !== want.base_kind) bad = {bad, " base_kind"};
				if (m_tuser[2] !== want.bad_digit) bad = {bad, " bad_digit"};
				if (m_tuser[3] !== want.overflowed) bad = {bad, " overflowed"};
				if (m_tuser[4] !== want.no_digits) bad = {bad, " no_digits"};
				if (m_tuser[5] !== want.bad_start) bad = {bad, " bad_start"};
				if (bad != "") begin
					report_mismatch($sformatf(
						"result %0d:%s got %h/%b expected %h/%b", results_checked, bad,
						m_tdata, m_tuser, want.value,
						{want.bad_start, want.no_digits, want.overflowed, want.bad_digit,
						want.base_kind}));
				end
			end
			results_checked++;
		end
	end

	// watchdog: no beat on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a beat", IDLE_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int dir_chars;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		clear_literal();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			for (int j = 0; j < dir_text[i].len(); j++) begin
				send_char(dir_text[i][j], j == dir_text[i].len() - 1, dir_typed[i],
					dir_want[i]);
			end
		end
		dir_chars = chars_sent;

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			while (chars_sent < dir_chars + (p + 1) * PHASE_CHARS) send_random_literal();
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d characters in %0d literals (all bases, prefixes, separators,",
			chars_sent, literals_sent);
		$display("bad digits, overflow, max values, noise); %0d results, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
